// ----- src/cvm_pkg.sv -----
// Shared types and constants for the conv2d valid-mode MAC engine.
// Request/result payloads, decoded queue entry and command/register codes.
// No dependencies.
package cvm_pkg;

   // command codes carried in the request
   localparam logic [1:0] CMD_WEIGHT  = 2'd0;
   localparam logic [1:0] CMD_BIAS    = 2'd1;
   localparam logic [1:0] CMD_PIXEL   = 2'd2;
   localparam logic [1:0] CMD_COMPUTE = 2'd3;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_IN_CHANS  = 3'd0;
   localparam logic [2:0] REG_OUT_CHANS = 3'd1;
   localparam logic [2:0] REG_KERNEL    = 3'd2;
   localparam logic [2:0] REG_ROWS      = 3'd3;
   localparam logic [2:0] REG_COLS      = 3'd4;

   localparam int CSR_AW      = 5;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [2:0]         out_chan;
      logic [1:0]         in_chan;
      logic [4:0]         row_pos;
      logic [4:0]         col_pos;
      logic signed [31:0] data_value;
   } req_type;

   typedef struct packed {
      logic signed [47:0] conv_result;
      logic               out_of_range;
   } rsp_type;

   // decoded operation handed from front to back
   typedef enum logic [2:0] {
      OP_WEIGHT  = 3'd0,
      OP_BIAS    = 3'd1,
      OP_PIXEL   = 3'd2,
      OP_COMPUTE = 3'd3,
      OP_FLAG    = 3'd4
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [2:0]         out_chan;
      logic [1:0]         in_chan;
      logic [4:0]         row_pos;
      logic [4:0]         col_pos;
      logic signed [31:0] data_value;  // saturated for weight and pixel
      logic [2:0]         nin;         // clamped input channel count
      logic [1:0]         kside;       // clamped kernel side
   } entry_type;

endpackage

// ----- src/cvm_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cvm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 288,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- src/cvm_front.sv -----
// Front end: APB register file, request acceptance and classification.
// Saturates write data, drops writes outside the stores, flags bad positions.
// Depends on cvm_pkg.
module cvm_front #(
   parameter int MAX_IN_CHANS  = 4,
   parameter int MAX_OUT_CHANS = 8,
   parameter int MAX_KERNEL    = 3,
   parameter int MAX_ROWS      = 32,
   parameter int MAX_COLS      = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [cvm_pkg::CSR_AW-1:0]    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   input  logic                          start,
   input  cvm_pkg::req_type              req_data,
   input  logic                          q_full,
   output logic                          q_push,
   output cvm_pkg::entry_type            q_entry
);
   import cvm_pkg::*;

   logic [2:0] in_chans_ff,  in_chans_in;
   logic [3:0] out_chans_ff, out_chans_in;
   logic [1:0] kernel_ff,    kernel_in;
   logic [5:0] rows_ff,      rows_in;
   logic [5:0] cols_ff,      cols_in;

   logic       csr_wr;
   logic [2:0] reg_idx;
   logic [2:0] nin;
   logic [3:0] nout;
   logic [1:0] kside;
   logic [5:0] rows;
   logic [5:0] cols;
   logic       outside;
   logic       wgt_ok;
   logic       bias_ok;
   logic       pix_ok;
   logic signed [31:0] sat_data;

   function automatic logic [5:0] clamp_reg(input logic [5:0] v, input int unsigned hi);
      logic [5:0] res;
      if (v == 6'd0) begin
         res = 6'd1;
      end else if (32'(v) > hi) begin
         res = 6'(hi);
      end else begin
         res = v;
      end
      return res;
   endfunction

   assign csr_wr  = psel & penable & pwrite;
   assign reg_idx = paddr[4:2];

   always_comb begin
      in_chans_in  = in_chans_ff;
      out_chans_in = out_chans_ff;
      kernel_in    = kernel_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      if (csr_wr) begin
         unique case (reg_idx)
            REG_IN_CHANS:  in_chans_in  = pwdata[2:0];
            REG_OUT_CHANS: out_chans_in = pwdata[3:0];
            REG_KERNEL:    kernel_in    = pwdata[1:0];
            REG_ROWS:      rows_in      = pwdata[5:0];
            REG_COLS:      cols_in      = pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_chans_ff  <= 3'd4;
         out_chans_ff <= 4'd8;
         kernel_ff    <= 2'd3;
         rows_ff      <= 6'd32;
         cols_ff      <= 6'd32;
      end else begin
         in_chans_ff  <= in_chans_in;
         out_chans_ff <= out_chans_in;
         kernel_ff    <= kernel_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_IN_CHANS:  prdata = {29'd0, in_chans_ff};
         REG_OUT_CHANS: prdata = {28'd0, out_chans_ff};
         REG_KERNEL:    prdata = {30'd0, kernel_ff};
         REG_ROWS:      prdata = {26'd0, rows_ff};
         REG_COLS:      prdata = {26'd0, cols_ff};
         default:       prdata = 32'd0;
      endcase
   end

   // effective sizes; each result never exceeds its register's range
   assign nin   = 3'(clamp_reg({3'b0, in_chans_ff}, MAX_IN_CHANS));
   assign nout  = 4'(clamp_reg({2'b0, out_chans_ff}, MAX_OUT_CHANS));
   assign kside = 2'(clamp_reg({4'b0, kernel_ff}, MAX_KERNEL));
   assign rows  = clamp_reg(rows_ff, MAX_ROWS);
   assign cols  = clamp_reg(cols_ff, MAX_COLS);

   assign outside = ({1'b0, req_data.out_chan} >= nout)
                 || (({2'b0, req_data.row_pos} + {5'b0, kside}) > {1'b0, rows})
                 || (({2'b0, req_data.col_pos} + {5'b0, kside}) > {1'b0, cols});

   assign wgt_ok  = (32'(req_data.out_chan) < MAX_OUT_CHANS)
                 && (32'(req_data.in_chan) < MAX_IN_CHANS)
                 && (32'(req_data.row_pos) < MAX_KERNEL)
                 && (32'(req_data.col_pos) < MAX_KERNEL);
   assign bias_ok = (32'(req_data.out_chan) < MAX_OUT_CHANS);
   assign pix_ok  = (32'(req_data.in_chan) < MAX_IN_CHANS)
                 && (32'(req_data.row_pos) < MAX_ROWS)
                 && (32'(req_data.col_pos) < MAX_COLS);

   always_comb begin
      if (req_data.data_value > 32'sd32767) begin
         sat_data = 32'sd32767;
      end else if (req_data.data_value < -32'sd32768) begin
         sat_data = -32'sd32768;
      end else begin
         sat_data = req_data.data_value;
      end
   end

   always_comb begin
      q_entry.out_chan   = req_data.out_chan;
      q_entry.in_chan    = req_data.in_chan;
      q_entry.row_pos    = req_data.row_pos;
      q_entry.col_pos    = req_data.col_pos;
      q_entry.data_value = sat_data;
      q_entry.nin        = nin;
      q_entry.kside      = kside;
      q_entry.op         = OP_COMPUTE;
      q_push             = 1'b0;
      unique case (req_data.cmd)
         CMD_WEIGHT: begin
            q_entry.op = OP_WEIGHT;
            q_push     = wgt_ok;
         end
         CMD_BIAS: begin
            q_entry.op         = OP_BIAS;
            q_entry.data_value = req_data.data_value;
            q_push             = bias_ok;
         end
         CMD_PIXEL: begin
            q_entry.op = OP_PIXEL;
            q_push     = pix_ok;
         end
         CMD_COMPUTE: begin
            q_entry.op = outside ? OP_FLAG : OP_COMPUTE;
            q_push     = 1'b1;
         end
         default: ;
      endcase
      q_push = q_push & start & ~q_full;
   end

endmodule

// ----- src/cvm_queue.sv -----
// Short FIFO of decoded operations between front and back.
// Depends on cvm_pkg.
module cvm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cvm_pkg::entry_type push_entry,
   input  logic               pop,
   output cvm_pkg::entry_type head,
   output logic               empty,
   output logic               full
);
   import cvm_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff,  count_in;

   assign empty = (count_ff == CW'(0));
   assign full  = (count_ff == CW'(QUEUE_DEPTH));
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- src/cvm_back.sv -----
// Back end: store writes and the shared multiply-accumulate sequencer.
// Holds the weight, bias and image RAMs. Depends on cvm_pkg and cvm_ram.
module cvm_back #(
   parameter int MAX_IN_CHANS  = 4,
   parameter int MAX_OUT_CHANS = 8,
   parameter int MAX_KERNEL    = 3,
   parameter int MAX_ROWS      = 32,
   parameter int MAX_COLS      = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  cvm_pkg::entry_type q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   output cvm_pkg::rsp_type   rsp_data
);
   import cvm_pkg::*;

   localparam int W_DEPTH = MAX_OUT_CHANS * MAX_IN_CHANS * MAX_KERNEL * MAX_KERNEL;
   localparam int I_DEPTH = MAX_IN_CHANS * MAX_ROWS * MAX_COLS;
   localparam int WA = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
   localparam int IA = (I_DEPTH > 1) ? $clog2(I_DEPTH) : 1;
   localparam int BA = (MAX_OUT_CHANS > 1) ? $clog2(MAX_OUT_CHANS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] oc_ff, oc_in;
   logic [4:0] r_ff, r_in;
   logic [4:0] c_ff, c_in;
   logic [2:0] nin_ff, nin_in;
   logic [1:0] k_ff, k_in;
   logic [2:0] ic_ff, ic_in;
   logic [1:0] kh_ff, kh_in;
   logic [1:0] kw_ff, kw_in;
   logic       bias_load_ff, bias_load_in;
   logic       rd_v_ff, rd_v_in;
   logic       prod_v_ff;
   logic signed [31:0] prod_ff;
   logic signed [47:0] acc_ff, acc_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic       idle;
   logic       last_tap;
   logic [2:0] sel_o;
   logic [2:0] sel_i;
   logic [4:0] sel_kh;
   logic [4:0] sel_kw;
   logic [5:0] sel_pr;
   logic [5:0] sel_pc;
   logic [WA-1:0] w_addr;
   logic [IA-1:0] p_addr;
   logic [BA-1:0] b_addr;
   logic          w_we, b_we, p_we;
   logic signed [15:0] w_rdata;
   logic signed [15:0] p_rdata;
   logic signed [31:0] b_rdata;

   assign idle  = (state_ff == ST_IDLE);
   assign q_pop = idle & ~q_empty;

   // one address path serves both the write at pop time and the tap reads
   always_comb begin
      if (idle) begin
         sel_o  = q_head.out_chan;
         sel_i  = {1'b0, q_head.in_chan};
         sel_kh = q_head.row_pos;
         sel_kw = q_head.col_pos;
         sel_pr = {1'b0, q_head.row_pos};
         sel_pc = {1'b0, q_head.col_pos};
      end else begin
         sel_o  = oc_ff;
         sel_i  = ic_ff;
         sel_kh = {3'b0, kh_ff};
         sel_kw = {3'b0, kw_ff};
         sel_pr = {1'b0, r_ff} + {4'b0, kh_ff};
         sel_pc = {1'b0, c_ff} + {4'b0, kw_ff};
      end
   end

   assign w_addr = WA'(((32'(sel_o) * MAX_IN_CHANS + 32'(sel_i)) * MAX_KERNEL
                        + 32'(sel_kh)) * MAX_KERNEL + 32'(sel_kw));
   assign p_addr = IA'((32'(sel_i) * MAX_ROWS + 32'(sel_pr)) * MAX_COLS + 32'(sel_pc));
   assign b_addr = BA'(32'(q_head.out_chan));

   assign w_we = q_pop && (q_head.op == OP_WEIGHT);
   assign b_we = q_pop && (q_head.op == OP_BIAS);
   assign p_we = q_pop && (q_head.op == OP_PIXEL);

   cvm_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_wgt_ram (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_addr),
      .wr_data (q_head.data_value[15:0]),
      .rd_addr (w_addr),
      .rd_data (w_rdata)
   );

   cvm_ram #(.WIDTH(16), .DEPTH(I_DEPTH)) u_img_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_addr),
      .wr_data (q_head.data_value[15:0]),
      .rd_addr (p_addr),
      .rd_data (p_rdata)
   );

   cvm_ram #(.WIDTH(32), .DEPTH(MAX_OUT_CHANS)) u_bias_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_addr),
      .wr_data (q_head.data_value),
      .rd_addr (b_addr),
      .rd_data (b_rdata)
   );

   assign last_tap = (ic_ff == nin_ff - 3'd1) && (kh_ff == k_ff - 2'd1)
                  && (kw_ff == k_ff - 2'd1);

   always_comb begin
      state_in     = state_ff;
      oc_in        = oc_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      nin_in       = nin_ff;
      k_in         = k_ff;
      ic_in        = ic_ff;
      kh_in        = kh_ff;
      kw_in        = kw_ff;
      bias_load_in = 1'b0;
      rd_v_in      = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               case (q_head.op)
                  OP_COMPUTE: begin
                     oc_in        = q_head.out_chan;
                     r_in         = q_head.row_pos;
                     c_in         = q_head.col_pos;
                     nin_in       = q_head.nin;
                     k_in         = q_head.kside;
                     ic_in        = 3'd0;
                     kh_in        = 2'd0;
                     kw_in        = 2'd0;
                     bias_load_in = 1'b1;
                     state_in     = ST_RUN;
                  end
                  OP_FLAG: begin
                     rsp_valid_in             = 1'b1;
                     rsp_data_in.conv_result  = 48'sd0;
                     rsp_data_in.out_of_range = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            rd_v_in = 1'b1;
            if (last_tap) begin
               state_in = ST_DRAIN;
            end else if (kw_ff == k_ff - 2'd1) begin
               kw_in = 2'd0;
               if (kh_ff == k_ff - 2'd1) begin
                  kh_in = 2'd0;
                  ic_in = ic_ff + 3'd1;
               end else begin
                  kh_in = kh_ff + 2'd1;
               end
            end else begin
               kw_in = kw_ff + 2'd1;
            end
         end
         ST_DRAIN: begin
            if (!rd_v_ff && !prod_v_ff) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.conv_result  = acc_ff;
               rsp_data_in.out_of_range = 1'b0;
               state_in                 = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      if (bias_load_ff) begin
         acc_in = {{16{b_rdata[31]}}, b_rdata};
      end else if (prod_v_ff) begin
         acc_in = acc_ff + {{16{prod_ff[31]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bias_load_ff <= 1'b0;
         rd_v_ff      <= 1'b0;
         prod_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bias_load_ff <= bias_load_in;
         rd_v_ff      <= rd_v_in;
         prod_v_ff    <= rd_v_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      oc_ff       <= oc_in;
      r_ff        <= r_in;
      c_ff        <= c_in;
      nin_ff      <= nin_in;
      k_ff        <= k_in;
      ic_ff       <= ic_in;
      kh_ff       <= kh_in;
      kw_ff       <= kw_in;
      prod_ff     <= p_rdata * w_rdata;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // tap counters stay inside the active window
   a_tap_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> (ic_ff < nin_ff) && (kh_ff < k_ff) && (kw_ff < k_ff))
      else $error("tap counter outside active window");

   // a product only follows a tap read issued the cycle before
   a_prod_follows_read: assert property (@(posedge clock) disable iff (reset)
      prod_v_ff |-> $past(rd_v_ff))
      else $error("product without a preceding read");

   // bias load never collides with a product arriving at the accumulator
   a_bias_no_overlap: assert property (@(posedge clock) disable iff (reset)
      bias_load_ff |-> !prod_v_ff && !rd_v_ff)
      else $error("bias load overlaps accumulation");

   // a drained compute always strobes its result next cycle
   a_drain_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) && !rd_v_ff && !prod_v_ff |=> rsp_valid_ff && !rsp_data_ff.out_of_range)
      else $error("drained compute did not emit");

endmodule

// ----- src/conv2d_valid_mac_engine_unit.sv -----
// Top level of the conv2d valid-mode MAC engine: front, queue and back.
// Depends on cvm_pkg, cvm_front, cvm_queue, cvm_back (and cvm_ram via cvm_back).
//
// Items are taken when start is high and busy is low; busy rises only when the
// two-entry operation queue between the front and the back is full. Weight,
// bias and pixel writes are done when they leave the queue and give no result. A
// compute item is worked by one shared multiplier that reads one pixel and one
// weight per cycle, and it occupies the back end from leaving the queue to the
// result strobe; the three store RAMs with their registered reads and the
// product register lie on that path. A compute at a position outside the
// output gives its flagged result in the cycle after it leaves the queue.
// Each result is shown on rsp_data for exactly one cycle with rsp_valid high
// and cannot be held off. The stores are not cleared by reset: an entry must
// be written before any compute reads it.
module conv2d_valid_mac_engine_unit #(
   parameter int MAX_IN_CHANS  = 4,
   parameter int MAX_OUT_CHANS = 8,
   parameter int MAX_KERNEL    = 3,
   parameter int MAX_ROWS      = 32,
   parameter int MAX_COLS      = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [cvm_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   input  logic                       start,
   output logic                       busy,
   input  cvm_pkg::req_type           req_data,
   output logic                       rsp_valid,
   output cvm_pkg::rsp_type           rsp_data
);
   import cvm_pkg::*;

   logic      q_push;
   logic      q_pop;
   logic      q_empty;
   logic      q_full;
   entry_type q_entry;
   entry_type q_head;

   assign pready = 1'b1;
   assign busy   = q_full;

   cvm_front #(
      .MAX_IN_CHANS  (MAX_IN_CHANS),
      .MAX_OUT_CHANS (MAX_OUT_CHANS),
      .MAX_KERNEL    (MAX_KERNEL),
      .MAX_ROWS      (MAX_ROWS),
      .MAX_COLS      (MAX_COLS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .start    (start),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   cvm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty),
      .full       (q_full)
   );

   cvm_back #(
      .MAX_IN_CHANS  (MAX_IN_CHANS),
      .MAX_OUT_CHANS (MAX_OUT_CHANS),
      .MAX_KERNEL    (MAX_KERNEL),
      .MAX_ROWS      (MAX_ROWS),
      .MAX_COLS      (MAX_COLS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
